>>> src/assert_macros.svh
// Assertion macros shared by the incremental PID RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ipid_pkg.sv
// Types, widths and constants for the incremental PID core.
`timescale 1ns / 1ps

package ipid_pkg;

   localparam int unsigned CfgW   = 31;  // Q15.16 registers and drive
   localparam int unsigned DataW  = 16;  // measured / target
   localparam int unsigned ErrW   = 17;  // target - measured
   localparam int unsigned Diff1W = 18;  // e - e1
   localparam int unsigned Diff2W = 19;  // e - 2e1 + e2
   localparam int unsigned ProdW  = 50;  // gain times difference
   localparam int unsigned SumW   = 53;  // sum of three products
   localparam int unsigned IncW   = 32;  // clamped increment
   localparam int unsigned AccW   = 33;  // accumulator plus increment
   localparam int unsigned IdxW   = 3;

   localparam int unsigned InitOutputWhole = 150;
   localparam logic [CfgW-1:0] InitOutputQ16  = CfgW'(InitOutputWhole << 16);
   localparam logic [CfgW-1:0] StepLimitReset = CfgW'(6553600);
   localparam logic [CfgW-1:0] OutLimitReset  = CfgW'(6553600);

   typedef enum logic [IdxW-1:0] {
      REG_GAIN_P       = 3'd0,
      REG_GAIN_I       = 3'd1,
      REG_GAIN_D       = 3'd2,
      REG_STEP_LIMIT   = 3'd3,
      REG_OUTPUT_LIMIT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CfgW-1:0] gain_p;
      logic [CfgW-1:0] gain_i;
      logic [CfgW-1:0] gain_d;
      logic [CfgW-1:0] step_limit;
      logic [CfgW-1:0] output_limit;
   } cfg_type;

endpackage

>>> src/ipid_calc.sv
// Combinational PID increment, step clamp and output clamp for one item.
`timescale 1ns / 1ps

module ipid_calc import ipid_pkg::*; (
   input  cfg_type                  cfg,
   input  logic signed [DataW-1:0]  measured,
   input  logic signed [DataW-1:0]  target,
   input  logic                     open_loop,
   input  logic signed [ErrW-1:0]   err_prev,
   input  logic signed [ErrW-1:0]   err_prev2,
   input  logic        [CfgW-1:0]   acc,
   output logic signed [ErrW-1:0]   err,
   output logic        [CfgW-1:0]   drive
);

   logic signed [Diff1W-1:0] d1;
   logic signed [Diff2W-1:0] d2;
   logic signed [ProdW-1:0]  gp_x;
   logic signed [ProdW-1:0]  gi_x;
   logic signed [ProdW-1:0]  gd_x;
   logic signed [ProdW-1:0]  prod_p;
   logic signed [ProdW-1:0]  prod_i;
   logic signed [ProdW-1:0]  prod_d;
   logic signed [SumW-1:0]   sum;
   logic signed [SumW-1:0]   lim;
   logic signed [IncW-1:0]   inc;
   logic        [CfgW-1:0]   base;
   logic signed [AccW-1:0]   acc_sum;
   logic signed [AccW-1:0]   out_lim;

   assign err = ErrW'(target) - ErrW'(measured);
   assign d1  = Diff1W'(err) - Diff1W'(err_prev);
   assign d2  = Diff2W'(err) - (Diff2W'(err_prev) <<< 1) + Diff2W'(err_prev2);

   // gains are unsigned: zero-extend into the signed product width
   assign gp_x = $signed({{(ProdW-CfgW){1'b0}}, cfg.gain_p});
   assign gi_x = $signed({{(ProdW-CfgW){1'b0}}, cfg.gain_i});
   assign gd_x = $signed({{(ProdW-CfgW){1'b0}}, cfg.gain_d});

   assign prod_p = gp_x * ProdW'(d1);
   assign prod_i = gi_x * ProdW'(err);
   assign prod_d = gd_x * ProdW'(d2);

   assign sum = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
   assign lim = $signed({{(SumW-CfgW){1'b0}}, cfg.step_limit});

   always_comb begin
      priority if (sum > lim) begin
         inc = IncW'(lim);
      end else if (sum < -lim) begin
         inc = IncW'(-lim);
      end else begin
         inc = IncW'(sum);
      end
   end

   assign base    = open_loop ? '0 : acc;
   assign acc_sum = AccW'(inc) + $signed({{(AccW-CfgW){1'b0}}, base});
   assign out_lim = $signed({{(AccW-CfgW){1'b0}}, cfg.output_limit});

   always_comb begin
      priority if (acc_sum > out_lim) begin
         drive = cfg.output_limit;
      end else if (acc_sum < 0) begin
         drive = '0;
      end else begin
         drive = acc_sum[CfgW-1:0];
      end
   end

endmodule

>>> src/incremental_pid_clamped_core.sv
// Incremental PID controller core: registers, item pipeline and control state.
// Usage:
//   req_ channel carries one item (measured, target, open_loop) under
//   valid/ready. rsp_ channel returns one drive value per item, in order.
//   csr_ port writes gain_p, gain_i, gain_d, step_limit, output_limit by
//   index (0..4) on csr_write; other indexes are ignored. Write only while
//   no item is in flight.
// Pipeline: a taken item is held in the input register, then computed and
//   registered in the result register once that is free; rsp_valid stays high until the result is taken.
// Throughput: one item per cycle while rsp_ready is high. The error history and
//   accumulator close their loop through logic (three multiplies, sum, two clamps).
// Stall: when rsp_ready is low the result register holds; the input register
//   still takes one more item, then req_ready drops until the result moves.
// Reset (synchronous, active high): registers return to their reset values,
//   error history clears, accumulator loads 150.0 (Q15.16), pipeline empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module incremental_pid_clamped_core import ipid_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [DataW-1:0] req_measured,
   input  logic signed [DataW-1:0] req_target,
   input  logic                    req_open_loop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic        [CfgW-1:0]  rsp_drive,
   input  logic                    csr_write,
   input  logic        [IdxW-1:0]  csr_index,
   input  logic        [CfgW-1:0]  csr_wdata
);

   cfg_type                 cfg_ff;
   logic                    s1_valid_ff;
   logic signed [DataW-1:0] s1_measured_ff;
   logic signed [DataW-1:0] s1_target_ff;
   logic                    s1_open_loop_ff;
   logic signed [ErrW-1:0]  err_prev_ff;
   logic signed [ErrW-1:0]  err_prev2_ff;
   logic        [CfgW-1:0]  acc_ff;
   logic                    rsp_valid_ff;
   logic        [CfgW-1:0]  rsp_drive_ff;

   logic                    advance;
   logic                    take;
   logic signed [ErrW-1:0]  err_in;
   logic        [CfgW-1:0]  drive_in;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   ipid_calc u_calc (
      .cfg       (cfg_ff),
      .measured  (s1_measured_ff),
      .target    (s1_target_ff),
      .open_loop (s1_open_loop_ff),
      .err_prev  (err_prev_ff),
      .err_prev2 (err_prev2_ff),
      .acc       (acc_ff),
      .err       (err_in),
      .drive     (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p       <= '0;
         cfg_ff.gain_i       <= '0;
         cfg_ff.gain_d       <= '0;
         cfg_ff.step_limit   <= StepLimitReset;
         cfg_ff.output_limit <= OutLimitReset;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_GAIN_P:       cfg_ff.gain_p       <= csr_wdata;
            REG_GAIN_I:       cfg_ff.gain_i       <= csr_wdata;
            REG_GAIN_D:       cfg_ff.gain_d       <= csr_wdata;
            REG_STEP_LIMIT:   cfg_ff.step_limit   <= csr_wdata;
            REG_OUTPUT_LIMIT: cfg_ff.output_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_measured_ff  <= req_measured;
         s1_target_ff    <= req_target;
         s1_open_loop_ff <= req_open_loop;
      end
   end

   // controller state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         err_prev_ff  <= '0;
         err_prev2_ff <= '0;
         acc_ff       <= InitOutputQ16;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            err_prev_ff  <= err_in;
            err_prev2_ff <= err_prev_ff;
            acc_ff       <= drive_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff <= drive_in;
      end
   end

   `ASSERT_NEXT(a_drive_in_limit, clock, reset, advance, rsp_drive_ff <= $past(cfg_ff.output_limit), "drive above output_limit")
   `ASSERT_NEXT(a_history_shift, clock, reset, advance, err_prev2_ff == $past(err_prev_ff), "error history did not shift")
   `ASSERT_NEXT(a_acc_tracks_drive, clock, reset, advance, acc_ff == rsp_drive_ff, "accumulator differs from drive")
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(s1_valid_ff && !advance && take), "input register overwritten")

endmodule
